FILE: src/cau_pkg.sv
// Shared types, constants and payload structs of the complex arithmetic unit.
package cau_pkg;

    // fraction bits of the fixed-point words
    localparam int FRAC_BITS = 16;
    // one restoring step per numerator bit: 32 magnitude bits then 2*FRAC_BITS zeros
    localparam int NUM_STEPS = 2 * FRAC_BITS + 32;
    // quotient bits kept in the cells; anything above is only tracked as overflow
    localparam int QW = 34;
    // pipeline depth: two front stages, the cell row, three finishing stages
    localparam int DEPTH = NUM_STEPS + 5;

    localparam logic signed [31:0] POS_LIM = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NEG_LIM = 32'sh8000_0000;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_MUL  = 3'd1,
        OP_DIV  = 3'd2,
        OP_MAG  = 3'd3,
        OP_RCP  = 3'd4,
        OP_CONJ = 3'd5,
        OP_CMP  = 3'd6
    } t_op;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } t_in;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic               equal_flag;
        logic               div_zero_flag;
        logic               saturated_flag;
    } t_out;

    // operands and operation carried alongside the iterative work
    typedef struct packed {
        t_op                op;
        logic signed [31:0] a_r;
        logic signed [31:0] a_i;
        logic signed [31:0] b_r;
        logic signed [31:0] b_i;
    } t_side;

    // state handed from cell to cell
    typedef struct packed {
        t_side           side;
        logic            zero;
        logic [63:0]     d;
        logic [63:0]     rem_r;
        logic [63:0]     rem_i;
        logic [31:0]     num_r;
        logic [31:0]     num_i;
        logic [QW-1:0]   q_r;
        logic [QW-1:0]   q_i;
        logic            big_r;
        logic            big_i;
        logic            neg_r;
        logic            neg_i;
        logic [63:0]     sx;
        logic [63:0]     ss;
        logic [63:0]     sb;
    } t_cell;

endpackage

FILE: src/cau_norm.sv
// Front stages: select the operand, square its parts and load the first cell.
module cau_norm (
    input  logic           i_clk,
    input  logic           i_en,
    input  cau_pkg::t_in   i_data,
    output cau_pkg::t_cell o_cell
);

    cau_pkg::t_side     r_side;
    logic signed [31:0] r_x_r;
    logic signed [31:0] r_x_i;
    logic signed [63:0] r_sq_r;
    logic signed [63:0] r_sq_i;
    cau_pkg::t_cell     r_cell;
    cau_pkg::t_cell     n_cell;
    logic signed [31:0] x_r;
    logic signed [31:0] x_i;
    logic [63:0]        norm;

    // pick the divisor for divide, the first operand otherwise
    always_comb begin
        if (cau_pkg::t_op'(i_data.action) == cau_pkg::OP_DIV) begin
            x_r = i_data.b_real;
            x_i = i_data.b_imag;
        end else begin
            x_r = i_data.a_real;
            x_i = i_data.a_imag;
        end
    end

    // square both parts
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side.op  <= cau_pkg::t_op'(i_data.action);
            r_side.a_r <= i_data.a_real;
            r_side.a_i <= i_data.a_imag;
            r_side.b_r <= i_data.b_real;
            r_side.b_i <= i_data.b_imag;
            r_x_r      <= x_r;
            r_x_i      <= x_i;
            r_sq_r     <= x_r * x_r;
            r_sq_i     <= x_i * x_i;
        end
    end

    // form the norm and the starting state of divider and square root
    always_comb begin
        norm          = $unsigned(r_sq_r) + $unsigned(r_sq_i);
        n_cell        = '0;
        n_cell.side   = r_side;
        n_cell.zero   = (norm == 64'd0);
        n_cell.d      = norm;
        n_cell.num_r  = r_x_r[31] ? 32'(-r_x_r) : 32'(r_x_r);
        n_cell.num_i  = r_x_i[31] ? 32'(-r_x_i) : 32'(r_x_i);
        n_cell.neg_r  = r_x_r[31];
        n_cell.neg_i  = (r_x_i > 32'sd0);
        n_cell.sx     = norm;
        n_cell.sb     = 64'd1 << 62;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

FILE: src/cau_cell.sv
// One cell: a restoring divide step on both lanes and one square root step.
module cau_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  cau_pkg::t_cell i_cell,
    output cau_pkg::t_cell o_cell
);

    cau_pkg::t_cell r_cell;
    cau_pkg::t_cell n_cell;
    logic [63:0]    rem2_r;
    logic [63:0]    rem2_i;
    logic           ge_r;
    logic           ge_i;
    logic [63:0]    sq_t;

    always_comb begin
        n_cell = i_cell;
        // shift in the next numerator bit and try the subtract
        rem2_r = {i_cell.rem_r[62:0], i_cell.num_r[31]};
        rem2_i = {i_cell.rem_i[62:0], i_cell.num_i[31]};
        ge_r   = (rem2_r >= i_cell.d);
        ge_i   = (rem2_i >= i_cell.d);
        n_cell.rem_r = ge_r ? rem2_r - i_cell.d : rem2_r;
        n_cell.rem_i = ge_i ? rem2_i - i_cell.d : rem2_i;
        n_cell.num_r = {i_cell.num_r[30:0], 1'b0};
        n_cell.num_i = {i_cell.num_i[30:0], 1'b0};
        n_cell.big_r = i_cell.big_r | i_cell.q_r[cau_pkg::QW-1];
        n_cell.big_i = i_cell.big_i | i_cell.q_i[cau_pkg::QW-1];
        n_cell.q_r   = {i_cell.q_r[cau_pkg::QW-2:0], ge_r};
        n_cell.q_i   = {i_cell.q_i[cau_pkg::QW-2:0], ge_i};
        // square root digit; hold once the trial bit has run out
        sq_t = i_cell.ss + i_cell.sb;
        if (i_cell.sb != 64'd0) begin
            if (i_cell.sx >= sq_t) begin
                n_cell.sx = i_cell.sx - sq_t;
                n_cell.ss = (i_cell.ss >> 1) + i_cell.sb;
            end else begin
                n_cell.ss = i_cell.ss >> 1;
            end
            n_cell.sb = i_cell.sb >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

FILE: src/cau_finish.sv
// Back stages: round quotient and root, multiply, round, saturate and select.
module cau_finish (
    input  logic           i_clk,
    input  logic           i_en,
    input  cau_pkg::t_cell i_cell,
    output cau_pkg::t_out  o_data
);

    localparam logic signed [65:0] HALF = 66'sd1 <<< (cau_pkg::FRAC_BITS - 1);

    // {saturated, value} of a wide signed value clipped to 32 bits
    function automatic logic [32:0] clip_word(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, cau_pkg::POS_LIM};
        end else if (v < -66'sd2147483648) begin
            r = {1'b1, cau_pkg::NEG_LIM};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // {saturated, value} of a rounded quotient with its sign applied
    function automatic logic [32:0] recip_word(input logic [34:0] qr, input logic big,
                                               input logic neg);
        logic [32:0] r;
        if (neg) begin
            if (big || qr > 35'd2147483648) begin
                r = {1'b1, cau_pkg::NEG_LIM};
            end else begin
                r = {1'b0, (~qr[31:0]) + 32'd1};
            end
        end else begin
            if (big || qr > 35'd2147483647) begin
                r = {1'b1, cau_pkg::POS_LIM};
            end else begin
                r = {1'b0, qr[31:0]};
            end
        end
        return r;
    endfunction

    // stage one: rounding of reciprocal parts and root
    logic [34:0]        qr_r;
    logic [34:0]        qr_i;
    logic [32:0]        t_r;
    logic [32:0]        t_i;
    logic [63:0]        root;
    cau_pkg::t_side     r1_side;
    logic               r1_zero;
    logic signed [31:0] r1_t_r;
    logic signed [31:0] r1_t_i;
    logic               r1_rsat;
    logic signed [31:0] r1_mag;
    logic               r1_msat;

    always_comb begin
        qr_r = {1'b0, i_cell.q_r} + 35'(({i_cell.rem_r, 1'b0} >= {1'b0, i_cell.d}));
        qr_i = {1'b0, i_cell.q_i} + 35'(({i_cell.rem_i, 1'b0} >= {1'b0, i_cell.d}));
        t_r  = recip_word(qr_r, i_cell.big_r, i_cell.neg_r);
        t_i  = recip_word(qr_i, i_cell.big_i, i_cell.neg_i);
        root = i_cell.ss + 64'(i_cell.sx > i_cell.ss);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= i_cell.side;
            r1_zero <= i_cell.zero;
            r1_t_r  <= t_r[31:0];
            r1_t_i  <= t_i[31:0];
            r1_rsat <= t_r[32] | t_i[32];
            r1_msat <= (root > 64'd2147483647);
            r1_mag  <= (root > 64'd2147483647) ? cau_pkg::POS_LIM : root[31:0];
        end
    end

    // stage two: the four partial products
    logic signed [31:0] y_r;
    logic signed [31:0] y_i;
    cau_pkg::t_side     r2_side;
    logic               r2_zero;
    logic signed [31:0] r2_t_r;
    logic signed [31:0] r2_t_i;
    logic               r2_rsat;
    logic signed [31:0] r2_mag;
    logic               r2_msat;
    logic signed [63:0] r2_p_rr;
    logic signed [63:0] r2_p_ii;
    logic signed [63:0] r2_p_ri;
    logic signed [63:0] r2_p_ir;

    always_comb begin
        if (r1_side.op == cau_pkg::OP_DIV) begin
            y_r = r1_t_r;
            y_i = r1_t_i;
        end else begin
            y_r = r1_side.b_r;
            y_i = r1_side.b_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= r1_side;
            r2_zero <= r1_zero;
            r2_t_r  <= r1_t_r;
            r2_t_i  <= r1_t_i;
            r2_rsat <= r1_rsat;
            r2_mag  <= r1_mag;
            r2_msat <= r1_msat;
            r2_p_rr <= r1_side.a_r * y_r;
            r2_p_ii <= r1_side.a_i * y_i;
            r2_p_ri <= r1_side.a_r * y_i;
            r2_p_ir <= r1_side.a_i * y_r;
        end
    end

    // stage three: round the product sums and pick the result
    logic signed [65:0] s_r;
    logic signed [65:0] s_i;
    logic [32:0]        m_r;
    logic [32:0]        m_i;
    logic [32:0]        add_r;
    logic [32:0]        add_i;
    logic [32:0]        cj_i;
    cau_pkg::t_out      n_out;
    cau_pkg::t_out      r_out;

    always_comb begin
        s_r   = (66'(r2_p_rr) - 66'(r2_p_ii) + HALF) >>> cau_pkg::FRAC_BITS;
        s_i   = (66'(r2_p_ri) + 66'(r2_p_ir) + HALF) >>> cau_pkg::FRAC_BITS;
        m_r   = clip_word(s_r);
        m_i   = clip_word(s_i);
        add_r = clip_word(66'(r2_side.a_r) + 66'(r2_side.b_r));
        add_i = clip_word(66'(r2_side.a_i) + 66'(r2_side.b_i));
        cj_i  = clip_word(-66'(r2_side.a_i));
        n_out = '0;
        unique case (r2_side.op)
            cau_pkg::OP_ADD: begin
                n_out.res_real       = add_r[31:0];
                n_out.res_imag       = add_i[31:0];
                n_out.saturated_flag = add_r[32] | add_i[32];
            end
            cau_pkg::OP_MUL: begin
                n_out.res_real       = m_r[31:0];
                n_out.res_imag       = m_i[31:0];
                n_out.saturated_flag = m_r[32] | m_i[32];
            end
            cau_pkg::OP_DIV: begin
                if (r2_zero) begin
                    n_out.div_zero_flag = 1'b1;
                end else begin
                    n_out.res_real       = m_r[31:0];
                    n_out.res_imag       = m_i[31:0];
                    n_out.saturated_flag = r2_rsat | m_r[32] | m_i[32];
                end
            end
            cau_pkg::OP_MAG: begin
                n_out.res_real       = r2_mag;
                n_out.saturated_flag = r2_msat;
            end
            cau_pkg::OP_RCP: begin
                if (r2_zero) begin
                    n_out.div_zero_flag = 1'b1;
                end else begin
                    n_out.res_real       = r2_t_r;
                    n_out.res_imag       = r2_t_i;
                    n_out.saturated_flag = r2_rsat;
                end
            end
            cau_pkg::OP_CONJ: begin
                n_out.res_real       = r2_side.a_r;
                n_out.res_imag       = cj_i[31:0];
                n_out.saturated_flag = cj_i[32];
            end
            cau_pkg::OP_CMP: begin
                n_out.equal_flag = (r2_side.a_r == r2_side.b_r) &&
                                   (r2_side.a_i == r2_side.b_i);
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

FILE: src/complex_arithmetic_unit_top.sv
// The row of divider and square root cells sets the depth; it is the same for every operation.
// Throughput: one beat per cycle while the output is not stalled.
// The whole pipeline holds while a finished beat waits at a stalled output.
// Reset (synchronous, active low) clears the valid bits; no clearing pass is needed.
// Divide uses the reciprocal of the divisor, rounded and saturated, then one complex multiply.
// Top level of the complex arithmetic unit.
module complex_arithmetic_unit_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cau_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output cau_pkg::t_out o_data
);

    logic                         en;
    logic [cau_pkg::DEPTH-1:0]    r_vld;
    cau_pkg::t_cell               chain [cau_pkg::NUM_STEPS+1];

    // advance everything unless the output beat is held
    assign en      = !(r_vld[cau_pkg::DEPTH-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[cau_pkg::DEPTH-1];

    // track valid beats along the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[cau_pkg::DEPTH-2:0], i_valid};
        end
    end

    cau_norm u_norm (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (i_data),
        .o_cell (chain[0])
    );

    for (genvar g = 0; g < cau_pkg::NUM_STEPS; g++) begin : g_cell
        cau_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    cau_finish u_finish (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cell (chain[cau_pkg::NUM_STEPS]),
        .o_data (o_data)
    );

`ifndef SYNTHESIS
    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // the input is held back only by a waiting output beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall without a held output beat");

    // a zero divisor gives a clean zero result
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.div_zero_flag) |->
        (o_data.res_real == 32'sd0 && o_data.res_imag == 32'sd0 &&
         !o_data.saturated_flag && !o_data.equal_flag))
        else $error("divide by zero with nonzero result");

    // compare gives only the flag
    a_equal_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.equal_flag) |->
        (o_data.res_real == 32'sd0 && o_data.res_imag == 32'sd0 &&
         !o_data.saturated_flag))
        else $error("equal flag with nonzero result");
`endif

endmodule

FILE: tb/cau_checker.sv
// Checker of the complex arithmetic unit: predicts each beat and compares results in order.
module cau_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  cau_pkg::t_in   i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  cau_pkg::t_out  i_out_data,
    output int             o_errors,
    output int             o_pending
);

    localparam logic [127:0] U32_POS = 128'h7FFF_FFFF;
    localparam logic [127:0] U32_NEG = 128'h8000_0000;

    cau_pkg::t_out expected_results[$];

    // clip a wide signed value to 32 bits
    function automatic logic signed [31:0] clip_word(input logic signed [95:0] v,
                                                     inout bit sat);
        if (v > 96'sd2147483647) begin
            sat = 1'b1;
            return cau_pkg::POS_LIM;
        end
        if (v < -96'sd2147483648) begin
            sat = 1'b1;
            return cau_pkg::NEG_LIM;
        end
        return v[31:0];
    endfunction

    // round (p + q) / 2^F to nearest, ties toward plus infinity
    function automatic logic signed [31:0] scale_sum(input logic signed [95:0] p,
                                                     input logic signed [95:0] q,
                                                     inout bit sat);
        logic signed [95:0] t;
        t = p + q + (96'sd1 <<< (cau_pkg::FRAC_BITS - 1));
        return clip_word(t >>> cau_pkg::FRAC_BITS, sat);
    endfunction

    function automatic void complex_product(input logic signed [31:0] xr,
                                            input logic signed [31:0] xi,
                                            input logic signed [31:0] yr,
                                            input logic signed [31:0] yi,
                                            output logic signed [31:0] rr,
                                            output logic signed [31:0] ri,
                                            inout bit sat);
        logic signed [95:0] xr_w, xi_w, yr_w, yi_w;
        xr_w = xr;
        xi_w = xi;
        yr_w = yr;
        yi_w = yi;
        rr = scale_sum(xr_w * yr_w, -(xi_w * yi_w), sat);
        ri = scale_sum(xr_w * yi_w, xi_w * yr_w, sat);
    endfunction

    // round m * 2^(2F) / d, magnitude ties away from zero, then sign and clip
    function automatic logic signed [31:0] scaled_quotient(input logic [63:0] m,
                                                           input logic [63:0] d,
                                                           input bit neg,
                                                           inout bit sat);
        logic [127:0] num, q, r;
        num = {64'd0, m} << (2 * cau_pkg::FRAC_BITS);
        q = num / {64'd0, d};
        r = num % {64'd0, d};
        if ((r << 1) >= {64'd0, d})
            q = q + 1;
        if (neg) begin
            if (q > U32_NEG) begin
                sat = 1'b1;
                return cau_pkg::NEG_LIM;
            end
            return -q[31:0];
        end
        if (q > U32_POS) begin
            sat = 1'b1;
            return cau_pkg::POS_LIM;
        end
        return q[31:0];
    endfunction

    function automatic logic [63:0] norm_sq(input logic signed [31:0] r,
                                            input logic signed [31:0] i);
        longint rl, il;
        rl = r;
        il = i;
        return 64'(rl * rl) + 64'(il * il);
    endfunction

    function automatic logic [63:0] abs_word(input logic signed [31:0] v);
        longint vl;
        vl = v;
        return (vl < 0) ? 64'(-vl) : 64'(vl);
    endfunction

    // reciprocal; returns 0 when the operand is zero
    function automatic bit complex_recip(input logic signed [31:0] r,
                                         input logic signed [31:0] i,
                                         output logic signed [31:0] rr,
                                         output logic signed [31:0] ri,
                                         inout bit sat);
        logic [63:0] n;
        n = norm_sq(r, i);
        rr = '0;
        ri = '0;
        if (n == 0)
            return 1'b0;
        rr = scaled_quotient(abs_word(r), n, r < 0, sat);
        ri = scaled_quotient(abs_word(i), n, i > 0, sat);
        return 1'b1;
    endfunction

    // square root rounded to nearest
    function automatic logic [63:0] root_rounded(input logic [63:0] n);
        logic [63:0] s, t;
        s = '0;
        for (int b = 31; b >= 0; b--) begin
            t = s | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= {64'd0, n})
                s = t;
        end
        if (n - s * s > s)
            s = s + 1;
        return s;
    endfunction

    function automatic cau_pkg::t_out predict_result(input cau_pkg::t_in beat);
        cau_pkg::t_out res;
        bit sat;
        logic signed [31:0] tr, ti, rr, ri;
        logic signed [95:0] wa, wb;
        logic [63:0] root;
        res = '0;
        sat = 1'b0;
        rr = '0;
        ri = '0;
        case (beat.action)
            cau_pkg::OP_ADD: begin
                wa = beat.a_real;
                wb = beat.b_real;
                rr = clip_word(wa + wb, sat);
                wa = beat.a_imag;
                wb = beat.b_imag;
                ri = clip_word(wa + wb, sat);
            end
            cau_pkg::OP_MUL: begin
                complex_product(beat.a_real, beat.a_imag, beat.b_real, beat.b_imag,
                                rr, ri, sat);
            end
            cau_pkg::OP_DIV: begin
                if (complex_recip(beat.b_real, beat.b_imag, tr, ti, sat))
                    complex_product(beat.a_real, beat.a_imag, tr, ti, rr, ri, sat);
                else
                    res.div_zero_flag = 1'b1;
            end
            cau_pkg::OP_MAG: begin
                root = root_rounded(norm_sq(beat.a_real, beat.a_imag));
                if (root > 64'h7FFF_FFFF) begin
                    sat = 1'b1;
                    rr = cau_pkg::POS_LIM;
                end else begin
                    rr = root[31:0];
                end
            end
            cau_pkg::OP_RCP: begin
                if (!complex_recip(beat.a_real, beat.a_imag, rr, ri, sat))
                    res.div_zero_flag = 1'b1;
            end
            cau_pkg::OP_CONJ: begin
                rr = beat.a_real;
                wa = beat.a_imag;
                ri = clip_word(-wa, sat);
            end
            cau_pkg::OP_CMP: begin
                res.equal_flag = (beat.a_real == beat.b_real) &&
                                 (beat.a_imag == beat.b_imag);
            end
            default: ;
        endcase
        res.res_real = rr;
        res.res_imag = ri;
        res.saturated_flag = sat;
        return res;
    endfunction

    // queue accepted input beats, compare accepted output beats
    always @(posedge i_clk) begin
        cau_pkg::t_out want;
        if (!i_rst_n) begin
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_result(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want != i_out_data) begin
                        o_errors <= o_errors + 1;
                        if (want.res_real != i_out_data.res_real)
                            $error("res_real expected %h actual %h",
                                   want.res_real, i_out_data.res_real);
                        if (want.res_imag != i_out_data.res_imag)
                            $error("res_imag expected %h actual %h",
                                   want.res_imag, i_out_data.res_imag);
                        if (want.equal_flag != i_out_data.equal_flag)
                            $error("equal_flag expected %b actual %b",
                                   want.equal_flag, i_out_data.equal_flag);
                        if (want.div_zero_flag != i_out_data.div_zero_flag)
                            $error("div_zero_flag expected %b actual %b",
                                   want.div_zero_flag, i_out_data.div_zero_flag);
                        if (want.saturated_flag != i_out_data.saturated_flag)
                            $error("saturated_flag expected %b actual %b",
                                   want.saturated_flag, i_out_data.saturated_flag);
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

FILE: tb/complex_arithmetic_unit_top_tb.sv
// Testbench top of the complex arithmetic unit: stimulus, output stalls and verdict.
module complex_arithmetic_unit_top_tb;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = cau_pkg::DEPTH + 40;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    cau_pkg::t_in   i_data = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    cau_pkg::t_out  o_data;
    int             errors;
    int             pending;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             quiet_cycles = 0;

    complex_arithmetic_unit_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    cau_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // stall the result side at random
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hold one beat until accepted, with a random idle gap first; return at a falling edge
    task automatic send_beat(input cau_pkg::t_in beat);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= beat;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(6, 0))
            0: return cau_pkg::POS_LIM;
            1: return cau_pkg::NEG_LIM;
            2: return '0;
            3: return $signed($urandom_range(1 << 21, 0)) - (1 << 20);
            4: return ($urandom_range(1, 0) ? 32'sh0001_0000 : -32'sh0001_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic cau_pkg::t_in random_beat();
        cau_pkg::t_in beat;
        beat.action = cau_pkg::t_op'($urandom_range(cau_pkg::OP_CMP, cau_pkg::OP_ADD));
        beat.a_real = pick_word();
        beat.a_imag = pick_word();
        beat.b_real = pick_word();
        beat.b_imag = pick_word();
        // zero operands for divide and reciprocal, equal operands for compare
        if ($urandom_range(9, 0) == 0) begin
            if (beat.action == cau_pkg::OP_DIV) begin
                beat.b_real = '0;
                beat.b_imag = '0;
            end else if (beat.action == cau_pkg::OP_RCP) begin
                beat.a_real = '0;
                beat.a_imag = '0;
            end
        end
        if (beat.action == cau_pkg::OP_CMP && $urandom_range(1, 0)) begin
            beat.b_real = beat.a_real;
            beat.b_imag = beat.a_imag;
        end
        return beat;
    endfunction

    initial begin
        cau_pkg::t_in beat;
        int drain;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, every operation, zero divisor, saturating conjugate
        send_beat('{cau_pkg::OP_ADD, cau_pkg::POS_LIM, cau_pkg::NEG_LIM,
                    cau_pkg::POS_LIM, cau_pkg::NEG_LIM});
        send_beat('{cau_pkg::OP_ADD, 32'sh0001_8000, -32'sh0000_4000,
                    32'sh0002_0000, 32'sh0000_0001});
        send_beat('{cau_pkg::OP_MUL, cau_pkg::POS_LIM, cau_pkg::POS_LIM,
                    cau_pkg::POS_LIM, cau_pkg::NEG_LIM});
        send_beat('{cau_pkg::OP_MUL, cau_pkg::NEG_LIM, cau_pkg::NEG_LIM,
                    cau_pkg::NEG_LIM, cau_pkg::NEG_LIM});
        send_beat('{cau_pkg::OP_MUL, 32'sh0000_8000, 32'sh0000_0001,
                    32'sh0000_0001, 32'sh0000_8000});
        send_beat('{cau_pkg::OP_DIV, 32'sh0001_0000, 32'sh0001_0000, '0, '0});
        send_beat('{cau_pkg::OP_DIV, cau_pkg::POS_LIM, cau_pkg::NEG_LIM,
                    32'sh0000_0001, '0});
        send_beat('{cau_pkg::OP_DIV, 32'sh0003_0000, -32'sh0002_0000,
                    32'sh0001_0000, 32'sh0002_0000});
        send_beat('{cau_pkg::OP_DIV, cau_pkg::NEG_LIM, cau_pkg::POS_LIM,
                    cau_pkg::NEG_LIM, cau_pkg::NEG_LIM});
        send_beat('{cau_pkg::OP_MAG, cau_pkg::NEG_LIM, cau_pkg::NEG_LIM, '0, '0});
        send_beat('{cau_pkg::OP_MAG, 32'sh0003_0000, 32'sh0004_0000, '0, '0});
        send_beat('{cau_pkg::OP_MAG, '0, '0, cau_pkg::POS_LIM, cau_pkg::POS_LIM});
        send_beat('{cau_pkg::OP_RCP, '0, '0, cau_pkg::POS_LIM, cau_pkg::POS_LIM});
        send_beat('{cau_pkg::OP_RCP, 32'sh0000_0001, '0, '0, '0});
        send_beat('{cau_pkg::OP_RCP, cau_pkg::NEG_LIM, cau_pkg::NEG_LIM, '0, '0});
        send_beat('{cau_pkg::OP_RCP, '0, -32'sh0000_8000, '0, '0});
        send_beat('{cau_pkg::OP_CONJ, cau_pkg::POS_LIM, cau_pkg::NEG_LIM, '0, '0});
        send_beat('{cau_pkg::OP_CONJ, cau_pkg::NEG_LIM, cau_pkg::POS_LIM, -1, -1});
        send_beat('{cau_pkg::OP_CMP, cau_pkg::POS_LIM, cau_pkg::NEG_LIM,
                    cau_pkg::POS_LIM, cau_pkg::NEG_LIM});
        send_beat('{cau_pkg::OP_CMP, cau_pkg::POS_LIM, cau_pkg::NEG_LIM,
                    cau_pkg::POS_LIM, cau_pkg::POS_LIM});
        send_beat('{cau_pkg::OP_CMP, -1, -1, -1, -1});

        // random beats over the idle and stall phases
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                3: begin send_idle_pct = 12; recv_stall_pct = 12; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (240) begin
                beat = random_beat();
                send_beat(beat);
            end
        end
        // drop valid after the last beat
        i_valid <= 1'b0;

        // drain the pipeline, then keep watching for stray beats
        drain = 0;
        while (pending != 0 && drain < 50 * DRAIN_CYCLES) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
